[rtl/rse_pkg.sv]
package rse_pkg;

   localparam int unsigned SYM_W  = 8;
   localparam int unsigned K_W    = 4;
   localparam int unsigned PLANE_W = 2;
   localparam int unsigned CODE_W = 40;
   localparam int unsigned LEN_W  = 6;
   localparam int unsigned BUF_W  = 47;
   localparam int unsigned ESC_Q  = 32;
   localparam int unsigned MAX_K  = 8;
   localparam int unsigned CSR_AW = 4;
   localparam int unsigned CSR_DW = 32;

   localparam logic [PLANE_W-1:0] PLANE_LUMA     = 2'd0;
   localparam logic [PLANE_W-1:0] PLANE_CHROMA_U = 2'd1;

   typedef enum logic [1:0] {
      REG_K_LUMA,
      REG_K_CHROMA_U,
      REG_K_CHROMA_V
   } reg_index_type;

   // codeword right-aligned in code, len valid bits
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
      logic              eof;
   } code_type;

endpackage

[rtl/rse_front.sv]
module rse_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rse_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [rse_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [rse_pkg::CSR_DW-1:0]        csr_prdata,
   input  logic [rse_pkg::SYM_W-1:0]         symbol,
   input  logic [rse_pkg::PLANE_W-1:0]       plane,
   input  logic                              end_of_frame,
   output rse_pkg::code_type                 code
);

   logic [rse_pkg::K_W-1:0] k_luma_ff, k_luma_in;
   logic [rse_pkg::K_W-1:0] k_chroma_u_ff, k_chroma_u_in;
   logic [rse_pkg::K_W-1:0] k_chroma_v_ff, k_chroma_v_in;
   rse_pkg::reg_index_type  csr_index;
   logic                    csr_write;
   logic [rse_pkg::K_W-1:0] k_raw;
   logic [rse_pkg::K_W-1:0] k;
   logic [rse_pkg::SYM_W-1:0] z;
   logic [rse_pkg::SYM_W-1:0] q;
   logic [rse_pkg::SYM_W-1:0] rem_mask;
   logic [rse_pkg::CODE_W-1:0] ones;
   logic                    escape;

   assign csr_index = rse_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      k_luma_in     = k_luma_ff;
      k_chroma_u_in = k_chroma_u_ff;
      k_chroma_v_in = k_chroma_v_ff;
      if (csr_write) begin
         case (csr_index)
            rse_pkg::REG_K_LUMA:     k_luma_in     = csr_pwdata[rse_pkg::K_W-1:0];
            rse_pkg::REG_K_CHROMA_U: k_chroma_u_in = csr_pwdata[rse_pkg::K_W-1:0];
            rse_pkg::REG_K_CHROMA_V: k_chroma_v_in = csr_pwdata[rse_pkg::K_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_luma_ff     <= '0;
         k_chroma_u_ff <= '0;
         k_chroma_v_ff <= '0;
      end else begin
         k_luma_ff     <= k_luma_in;
         k_chroma_u_ff <= k_chroma_u_in;
         k_chroma_v_ff <= k_chroma_v_in;
      end
   end

   always_comb begin
      case (csr_index)
         rse_pkg::REG_K_LUMA:     csr_prdata = rse_pkg::CSR_DW'(k_luma_ff);
         rse_pkg::REG_K_CHROMA_U: csr_prdata = rse_pkg::CSR_DW'(k_chroma_u_ff);
         rse_pkg::REG_K_CHROMA_V: csr_prdata = rse_pkg::CSR_DW'(k_chroma_v_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // plane code 3 shares the second chroma k
   always_comb begin
      if (plane == rse_pkg::PLANE_LUMA) begin
         k_raw = k_luma_ff;
      end else if (plane == rse_pkg::PLANE_CHROMA_U) begin
         k_raw = k_chroma_u_ff;
      end else begin
         k_raw = k_chroma_v_ff;
      end
   end

   assign k = (k_raw > rse_pkg::K_W'(rse_pkg::MAX_K)) ? rse_pkg::K_W'(rse_pkg::MAX_K) : k_raw;

   // zigzag of symbol - 128
   assign z = symbol[7] ? {symbol[6:0], 1'b0} : ~{symbol[6:0], 1'b0};
   assign q = z >> k;
   assign escape = |q[7:5];
   assign rem_mask = rse_pkg::SYM_W'((9'd1 << k) - 9'd1);
   assign ones = (rse_pkg::CODE_W'(1) << q[4:0]) - rse_pkg::CODE_W'(1);

   always_comb begin
      code.eof = end_of_frame;
      if (escape) begin
         code.code = {{rse_pkg::ESC_Q{1'b1}}, z};
         code.len  = rse_pkg::LEN_W'(rse_pkg::CODE_W);
      end else begin
         code.code = (ones << (rse_pkg::LEN_W'(k) + rse_pkg::LEN_W'(1)))
                     | rse_pkg::CODE_W'(z & rem_mask);
         code.len  = rse_pkg::LEN_W'(q) + rse_pkg::LEN_W'(k) + rse_pkg::LEN_W'(1);
      end
   end

endmodule

[rtl/rse_queue.sv]
module rse_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rse_pkg::code_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output rse_pkg::code_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rse_pkg::code_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/rse_packer.sv]
module rse_packer (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  rse_pkg::code_type head,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast
);

   localparam int unsigned BW = rse_pkg::BUF_W;
   localparam int unsigned LW = rse_pkg::LEN_W;

   // bit buffer, first bit at the top, unused bits zero
   logic [BW-1:0] buf_ff, buf_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic          eof_ff, eof_in;
   logic          valid_ff, valid_in;
   logic [7:0]    data_ff, data_in;
   logic          last_ff, last_in;

   logic          out_free;
   logic          emit;
   logic          last;
   logic [BW-1:0] buf_a;
   logic [LW-1:0] cnt_a;
   logic          eof_a;
   logic [LW-1:0] shamt;

   assign out_free = ~valid_ff | rsp_tready;
   assign emit     = ((cnt_ff >= LW'(8)) | (eof_ff & (cnt_ff != '0))) & out_free;
   assign last     = eof_ff & (cnt_ff <= LW'(8));

   always_comb begin
      buf_a = buf_ff;
      cnt_a = cnt_ff;
      eof_a = eof_ff;
      if (emit) begin
         buf_a = buf_ff << 8;
         cnt_a = (cnt_ff >= LW'(8)) ? cnt_ff - LW'(8) : '0;
         eof_a = eof_ff & ~last;
      end
   end

   assign pop   = head_valid & (cnt_a < LW'(8)) & ~eof_a;
   assign shamt = LW'(BW) - cnt_a - head.len;

   always_comb begin
      buf_in = buf_a;
      cnt_in = cnt_a;
      eof_in = eof_a;
      if (pop) begin
         buf_in = buf_a | (BW'(head.code) << shamt);
         cnt_in = cnt_a + head.len;
         eof_in = head.eof;
      end
   end

   always_comb begin
      valid_in = valid_ff & ~rsp_tready;
      data_in  = data_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         data_in  = buf_ff[BW-1 -: 8];
         last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff   <= '0;
         cnt_ff   <= '0;
         eof_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         buf_ff   <= buf_in;
         cnt_ff   <= cnt_in;
         eof_ff   <= eof_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

[rtl/rice_symbol_stream_encoder.sv]
// channel  | dir | tdata          | tuser      | tlast
// req_     | in  | [7:0] symbol   | [1:0] plane| end_of_frame
// rsp_     | out | [7:0] out_byte | -          | last_byte
// csr_     | in  | APB, k_luma @0x0, k_chroma_u @0x4, k_chroma_v @0x8
//
// One request per cycle enters while the queue has room; its codeword is formed on acceptance.
// Packer sends one byte per cycle while the output is free and bits are buffered; it takes
// a request only when under eight bits remain and no frame end is pending, and req_tready
// falls while all QUEUE_DEPTH entries are taken.
// Output register holds a stalled byte while the next one is packed.
// Synchronous reset clears the k registers, bit buffer, queue and output valid.
module rice_symbol_stream_encoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic [1:0]  req_tuser,   // [1:0] plane
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   rse_pkg::code_type front_code;
   rse_pkg::code_type head;
   logic              queue_full;
   logic              head_valid;
   logic              pop;

   assign csr_pready = 1'b1;
   assign req_tready = ~queue_full;

   rse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .symbol       (req_tdata),
      .plane        (req_tuser),
      .end_of_frame (req_tlast),
      .code         (front_code)
   );

   rse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_data  (front_code),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   rse_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/rse_checker.sv]
module rse_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [3:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata
);

   // stalled byte stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp byte withdrawn under stall");

   // nothing offered straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // written k reads back in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_paddr == 4'h0
      ##1 csr_paddr == 4'h0 |-> csr_prdata == {28'h0, $past(csr_pwdata[3:0])})
      else $error("k_luma readback mismatch");

   // unmapped register reads zero
   assert property (@(posedge clock) disable iff (reset)
      csr_paddr[3:2] == 2'd3 |-> csr_prdata == 32'h0)
      else $error("unmapped register not zero");

endmodule

bind rice_symbol_stream_encoder rse_checker u_rse_checker (.*);
